// ===== rtl/core/gtc_pkg.sv =====
// Gesture classifier package: codes, configuration defaults and the structs
// passed between the classifier modules. No dependencies.
package gtc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MIN_SQ_W   = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TAP_SLOP       = 3'd0,
		CFG_SWIPE_MIN_DIST = 3'd1,
		CFG_SWIPE_MAX_DUR  = 3'd2,
		CFG_DTAP_TIMEOUT   = 3'd3,
		CFG_DTAP_SLOP      = 3'd4
	} cfg_idx_t;

	localparam logic [7:0]          RST_TAP_SLOP  = 8'd20;
	localparam logic [MIN_SQ_W-1:0] RST_MIN_SQ    = 24'd2500;
	localparam logic [15:0]         RST_MAX_DUR   = 16'd500;
	localparam logic [15:0]         RST_DTAP_TMO  = 16'd300;
	localparam logic [7:0]          RST_DTAP_SLOP = 8'd40;

	typedef enum logic [1:0] {
		EV_DOWN   = 2'd0,
		EV_MOVE   = 2'd1,
		EV_UP     = 2'd2,
		EV_CANCEL = 2'd3
	} ev_kind_t;

	typedef enum logic [1:0] {
		GST_IDLE  = 2'd0,
		GST_TOUCH = 2'd1,
		GST_SWIPE = 2'd2
	} gst_t;

	typedef enum logic [2:0] {
		G_NONE   = 3'd0,
		G_SINGLE = 3'd1,
		G_DOUBLE = 3'd2,
		G_FWD    = 3'd3,
		G_BACK   = 3'd4
	} gesture_t;

	typedef struct packed {
		logic [7:0]          tap_slop;
		logic [MIN_SQ_W-1:0] min_sq;
		logic [15:0]         max_dur;
		logic [15:0]         dtap_tmo;
		logic [7:0]          dtap_slop;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [31:0]        stamp;
		logic               has_focus;
	} item_t;

	typedef struct packed {
		gesture_t           gesture;
		logic signed [15:0] tap_x;
		logic signed [15:0] tap_y;
	} result_t;

endpackage

// ===== rtl/core/gtc_if.sv =====
// Valid/ready channels for pointer words and gesture result words.
// Depends on nothing but the handshake convention.
interface gtc_pointer_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [31:0]        stamp;
	logic               has_focus;

	modport source (output valid, kind, pos_x, pos_y, stamp, has_focus, input ready);
	modport sink   (input valid, kind, pos_x, pos_y, stamp, has_focus, output ready);
endinterface

interface gtc_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         gesture;
	logic signed [15:0] tap_x;
	logic signed [15:0] tap_y;

	modport source (output valid, gesture, tap_x, tap_y, input ready);
	modport sink   (input valid, gesture, tap_x, tap_y, output ready);
endinterface

// ===== rtl/core/gtc_cfg.sv =====
// Configuration registers of the gesture classifier, with the squared
// minimum swipe distance formed at write time. Depends on gtc_pkg.
module gtc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gtc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [gtc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output gtc_pkg::cfg_t                    cfg
);
	import gtc_pkg::*;

	cfg_t cfg_q;
	logic [MIN_SQ_W-1:0] min_sq;

	assign min_sq = cfg_data[11:0] * cfg_data[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_slop  <= RST_TAP_SLOP;
			cfg_q.min_sq    <= RST_MIN_SQ;
			cfg_q.max_dur   <= RST_MAX_DUR;
			cfg_q.dtap_tmo  <= RST_DTAP_TMO;
			cfg_q.dtap_slop <= RST_DTAP_SLOP;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TAP_SLOP:       cfg_q.tap_slop  <= cfg_data[7:0];
				CFG_SWIPE_MIN_DIST: cfg_q.min_sq    <= min_sq;
				CFG_SWIPE_MAX_DUR:  cfg_q.max_dur   <= cfg_data;
				CFG_DTAP_TIMEOUT:   cfg_q.dtap_tmo  <= cfg_data;
				CFG_DTAP_SLOP:      cfg_q.dtap_slop <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/gtc_core.sv =====
// Gesture state machine: touch start and last tap registers, swipe and tap
// classification of one pointer word per cycle while fire is high. Depends on gtc_pkg.
module gtc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  gtc_pkg::item_t   item,
	input  gtc_pkg::cfg_t    cfg,
	output gtc_pkg::result_t res
);
	import gtc_pkg::*;

	gst_t               state_q, state_nxt;
	logic signed [15:0] start_x_q, start_y_q, last_x_q, last_y_q;
	logic [31:0]        start_t_q, last_t_q;

	logic signed [16:0] dx, dy, lx, ly;
	logic [15:0]        adx, ady, alx, aly;
	logic [31:0]        sqx, sqy;
	logic [32:0]        d2;
	logic signed [32:0] dur, gap;
	logic               moved, swipe_ok, fwd, dbl;
	logic               is_single, is_double;
	ev_kind_t           kind;

	assign kind = ev_kind_t'(item.kind);

	assign dx = {item.pos_x[15], item.pos_x} - {start_x_q[15], start_x_q};
	assign dy = {item.pos_y[15], item.pos_y} - {start_y_q[15], start_y_q};
	assign lx = {item.pos_x[15], item.pos_x} - {last_x_q[15], last_x_q};
	assign ly = {item.pos_y[15], item.pos_y} - {last_y_q[15], last_y_q};

	function automatic logic [15:0] mag17(input logic signed [16:0] v);
		logic signed [16:0] n;
		n = -v;
		return v[16] ? n[15:0] : v[15:0];
	endfunction

	assign adx = mag17(dx);
	assign ady = mag17(dy);
	assign alx = mag17(lx);
	assign aly = mag17(ly);

	assign sqx = adx * adx;
	assign sqy = ady * ady;
	assign d2  = {1'b0, sqx} + {1'b0, sqy};

	assign dur = $signed({1'b0, item.stamp}) - $signed({1'b0, start_t_q});
	assign gap = $signed({1'b0, item.stamp}) - $signed({1'b0, last_t_q});

	assign moved    = (adx > {8'd0, cfg.tap_slop}) || (ady > {8'd0, cfg.tap_slop});
	assign swipe_ok = (d2 >= {9'd0, cfg.min_sq}) &&
	                  (dur <= $signed({17'd0, cfg.max_dur}));
	assign fwd      = (adx >= ady) ? (!dx[16] && dx != '0) : (!dy[16] && dy != '0);
	assign dbl      = item.has_focus && (gap <= $signed({17'd0, cfg.dtap_tmo})) &&
	                  (alx <= {8'd0, cfg.dtap_slop}) && (aly <= {8'd0, cfg.dtap_slop});

	always_comb begin
		state_nxt = state_q;
		unique case (kind)
			EV_DOWN:   state_nxt = GST_TOUCH;
			EV_MOVE:   if (state_q == GST_TOUCH && moved) state_nxt = GST_SWIPE;
			EV_UP:     state_nxt = GST_IDLE;
			EV_CANCEL: state_nxt = GST_IDLE;
			default:   state_nxt = state_q;
		endcase
	end

	always_comb begin
		res       = '{gesture: G_NONE, tap_x: '0, tap_y: '0};
		is_single = 1'b0;
		is_double = 1'b0;
		if (kind == EV_UP) begin
			if (state_q == GST_SWIPE) begin
				if (swipe_ok) res.gesture = fwd ? G_FWD : G_BACK;
			end else if (state_q == GST_TOUCH) begin
				if (dbl) begin
					res.gesture = G_DOUBLE;
					is_double   = 1'b1;
				end else begin
					res.gesture = G_SINGLE;
					res.tap_x   = item.pos_x;
					res.tap_y   = item.pos_y;
					is_single   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= GST_IDLE;
			start_x_q <= '0;
			start_y_q <= '0;
			start_t_q <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			last_t_q  <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
			if (kind == EV_DOWN) begin
				start_x_q <= item.pos_x;
				start_y_q <= item.pos_y;
				start_t_q <= item.stamp;
			end
			if (is_single) begin
				last_x_q <= item.pos_x;
				last_y_q <= item.pos_y;
				last_t_q <= item.stamp;
			end else if (is_double) begin
				last_t_q <= '0;
			end
		end
	end

endmodule

// ===== rtl/core/touch_gesture_classifier.sv =====
// Classifies pointer words (down, move, up, cancel) into taps, double taps
// and swipes, one result word for every pointer word. A word is taken every
// cycle while the result side keeps up; each word passes the input register,
// then the combinational classifier (two 16x16 squarers, an add and compare),
// then the result register, which holds it until the result side takes it.
// A stalled result holds the input once both registers are full. Depends on
// gtc_pkg, gtc_if, gtc_cfg and gtc_core.
module touch_gesture_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	gtc_pointer_if.sink                    pointer,
	gtc_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [gtc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gtc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gtc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res, res_s2;
	logic    valid_s2;
	logic    adv, fire, take;

	assign adv           = !valid_s2 || result.ready;
	assign fire          = valid_s1 && adv;
	assign pointer.ready = !valid_s1 || adv;
	assign take          = pointer.valid && pointer.ready;

	gtc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	gtc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind      <= pointer.kind;
			item_s1.pos_x     <= pointer.pos_x;
			item_s1.pos_y     <= pointer.pos_y;
			item_s1.stamp     <= pointer.stamp;
			item_s1.has_focus <= pointer.has_focus;
		end
		if (fire) res_s2 <= res;
	end

	assign result.valid   = valid_s2;
	assign result.gesture = res_s2.gesture;
	assign result.tap_x   = res_s2.tap_x;
	assign result.tap_y   = res_s2.tap_y;

endmodule

// ===== tb/gesture_checker.sv =====
// Gesture checker: watches the pointer, result and register ports of the
// gesture classifier, predicts each result word and compares it.
// Depends on gtc_pkg and gtc_if.
module gesture_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	gtc_pointer_if                         pointer,
	gtc_result_if                          result,
	input  logic                           cfg_we,
	input  logic [gtc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gtc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import gtc_pkg::*;

	localparam int DEF_MIN_DIST = 50;

	int tap_slop;
	int min_dist;
	int max_dur;
	int dtap_tmo;
	int dtap_slop;

	gst_t   touch_st;
	int     start_x;
	int     start_y;
	longint start_t;
	int     last_x;
	int     last_y;
	longint last_t;

	result_t expected_gestures[$];

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic result_t classify_pointer(item_t w);
		result_t r;
		int      x;
		int      y;
		int      dx;
		int      dy;
		longint  t;
		longint  d2;
		longint  m2;
		longint  dur;
		longint  gap;
		gst_t    prev;
		logic    dbl;
		logic    fwd;
		r.gesture = G_NONE;
		r.tap_x = '0;
		r.tap_y = '0;
		x = int'($signed(w.pos_x));
		y = int'($signed(w.pos_y));
		t = longint'({32'd0, w.stamp});
		case (w.kind)
			EV_DOWN: begin
				start_x = x;
				start_y = y;
				start_t = t;
				touch_st = GST_TOUCH;
			end
			EV_MOVE: begin
				if (touch_st == GST_TOUCH &&
				    (mag(x - start_x) > tap_slop || mag(y - start_y) > tap_slop))
					touch_st = GST_SWIPE;
			end
			EV_UP: begin
				prev = touch_st;
				touch_st = GST_IDLE;
				if (prev == GST_SWIPE) begin
					dx = x - start_x;
					dy = y - start_y;
					d2 = longint'(dx) * dx + longint'(dy) * dy;
					m2 = longint'(min_dist) * min_dist;
					dur = t - start_t;
					if (d2 >= m2 && dur <= max_dur) begin
						fwd = (mag(dx) >= mag(dy)) ? (dx > 0) : (dy > 0);
						r.gesture = fwd ? G_FWD : G_BACK;
					end
				end else if (prev == GST_TOUCH) begin
					gap = t - last_t;
					dbl = w.has_focus && gap <= dtap_tmo &&
					      mag(x - last_x) <= dtap_slop && mag(y - last_y) <= dtap_slop;
					if (dbl) begin
						r.gesture = G_DOUBLE;
						last_t = 0;
					end else begin
						r.gesture = G_SINGLE;
						r.tap_x = w.pos_x;
						r.tap_y = w.pos_y;
						last_x = x;
						last_y = y;
						last_t = t;
					end
				end
			end
			default: touch_st = GST_IDLE;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		item_t   w;
		if (!arst_n) begin
			tap_slop = RST_TAP_SLOP;
			min_dist = DEF_MIN_DIST;
			max_dur = RST_MAX_DUR;
			dtap_tmo = RST_DTAP_TMO;
			dtap_slop = RST_DTAP_SLOP;
			touch_st = GST_IDLE;
			start_x = 0;
			start_y = 0;
			start_t = 0;
			last_x = 0;
			last_y = 0;
			last_t = 0;
			expected_gestures.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_TAP_SLOP:       tap_slop = cfg_data[7:0];
					CFG_SWIPE_MIN_DIST: min_dist = cfg_data[11:0];
					CFG_SWIPE_MAX_DUR:  max_dur = cfg_data[15:0];
					CFG_DTAP_TIMEOUT:   dtap_tmo = cfg_data[15:0];
					CFG_DTAP_SLOP:      dtap_slop = cfg_data[7:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_gestures.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word, expected none, actual gesture %0d x %0d y %0d",
					         $time, result.gesture, result.tap_x, result.tap_y);
				end else begin
					want = expected_gestures.pop_front();
					if (result.gesture !== want.gesture) begin
						errors++;
						$display("%0t: gesture expected %0d actual %0d",
						         $time, want.gesture, result.gesture);
					end
					if (result.tap_x !== want.tap_x) begin
						errors++;
						$display("%0t: tap_x expected %0d actual %0d",
						         $time, want.tap_x, result.tap_x);
					end
					if (result.tap_y !== want.tap_y) begin
						errors++;
						$display("%0t: tap_y expected %0d actual %0d",
						         $time, want.tap_y, result.tap_y);
					end
				end
			end
			if (pointer.valid && pointer.ready) begin
				w.kind = pointer.kind;
				w.pos_x = pointer.pos_x;
				w.pos_y = pointer.pos_y;
				w.stamp = pointer.stamp;
				w.has_focus = pointer.has_focus;
				expected_gestures.push_back(classify_pointer(w));
			end
			outstanding = expected_gestures.size();
		end
	end

endmodule

// ===== tb/tb_touch_gesture_classifier.sv =====
// Testbench top for the gesture classifier: drives pointer words and register
// writes with random idling, and gives the verdict from gesture_checker.
// Depends on gtc_pkg, gtc_if, gesture_checker and the classifier RTL.
module tb_touch_gesture_classifier;
	timeunit 1ns;
	timeprecision 1ps;
	import gtc_pkg::*;

	localparam int ITEMS_PER_PHASE = 250;
	localparam int PHASES          = 7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gtc_pointer_if pointer ();
	gtc_result_if  result ();

	int          errors;
	int          outstanding;
	int          sent = 0;
	bit          quiet = 1'b0;
	logic [31:0] cur_t = 32'd0;
	int          s_slop = 20;
	int          s_min = 50;
	int          s_dur = 500;
	int          s_tmo = 300;
	int          s_dslop = 40;

	touch_gesture_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pointer  (pointer),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	gesture_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.pointer     (pointer),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int jitter(int span);
		int v;
		v = $urandom_range(0, 2 * span);
		return v - span;
	endfunction

	// hold ready low for random stretches
	initial begin
		int hold;
		hold = 0;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (quiet || $urandom_range(0, 99) < 70) begin
				result.ready = 1'b1;
			end else begin
				result.ready = 1'b0;
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
			end
		end
	end

	task automatic put_word(ev_kind_t k, int x, int y, logic [31:0] t, bit f);
		int n;
		pointer.kind = k;
		pointer.pos_x = 16'(x);
		pointer.pos_y = 16'(y);
		pointer.stamp = t;
		pointer.has_focus = f;
		pointer.valid = 1'b1;
		do @(posedge clk); while (!pointer.ready);
		@(negedge clk);
		sent++;
		if (sent % 64 == 0)
			quiet = ($urandom_range(0, 3) == 0);
		n = idle_len();
		if (n > 0) begin
			pointer.valid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value, int width, bit junk);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'(value);
		if (junk && width < CFG_DATA_W)
			d = d | CFG_DATA_W'($urandom << width);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = d;
		@(negedge clk);
	endtask

	task automatic settle();
		pointer.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_setting(int phase);
		int  v [5];
		bit  junk;
		case (phase)
			1: v = '{0, 0, 0, 0, 0};
			2: v = '{255, 4095, 65535, 65535, 255};
			3: v = '{20, 50, 500, 300, 40};
			6: v = '{$urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 65535),
			         $urandom_range(0, 65535), $urandom_range(0, 255)};
			default: v = '{$urandom_range(0, 60), $urandom_range(0, 400), $urandom_range(50, 2000),
			               $urandom_range(50, 1000), $urandom_range(0, 80)};
		endcase
		junk = (phase >= 4);
		write_reg(CFG_TAP_SLOP, v[0], 8, junk);
		write_reg(CFG_SWIPE_MIN_DIST, v[1], 12, junk);
		write_reg(CFG_SWIPE_MAX_DUR, v[2], 16, junk);
		write_reg(CFG_DTAP_TIMEOUT, v[3], 16, junk);
		write_reg(CFG_DTAP_SLOP, v[4], 8, junk);
		// drop writes to unused indexes
		write_reg(CFG_IDX_W'($urandom_range(CFG_DTAP_SLOP + 1, (1 << CFG_IDX_W) - 1)),
		          $urandom, CFG_DATA_W, 1'b0);
		cfg_we = 1'b0;
		s_slop = v[0];
		s_min = v[1];
		s_dur = v[2];
		s_tmo = v[3];
		s_dslop = v[4];
	endtask

	task automatic run_directed();
		put_word(EV_MOVE, 100, 100, 32'd1, 1'b1);
		put_word(EV_DOWN, 3, -4, 32'd10, 1'b1);
		put_word(EV_UP, 3, -4, 32'd20, 1'b1);
		put_word(EV_DOWN, 0, 0, 32'd8000, 1'b1);
		put_word(EV_DOWN, 1000, 1000, 32'd8010, 1'b1);
		put_word(EV_UP, 1000, 1000, 32'd8020, 1'b1);
		put_word(EV_DOWN, 1020, 1000, 32'd8100, 1'b1);
		put_word(EV_UP, 1020, 1000, 32'd8120, 1'b1);
		put_word(EV_DOWN, 32767, -32768, 32'hFFFF_FF00, 1'b0);
		put_word(EV_UP, 32767, -32768, 32'hFFFF_FFFF, 1'b0);
		put_word(EV_DOWN, 32760, -32760, 32'd5, 1'b1);
		put_word(EV_UP, 32760, -32760, 32'd6, 1'b1);
		put_word(EV_DOWN, 0, 0, 32'd1000, 1'b0);
		put_word(EV_MOVE, 30, 0, 32'd1010, 1'b0);
		put_word(EV_MOVE, -500, 9, 32'd1020, 1'b0);
		put_word(EV_UP, 60, 10, 32'd1100, 1'b0);
		put_word(EV_DOWN, 0, 0, 32'd2000, 1'b1);
		put_word(EV_MOVE, 40, 40, 32'd2005, 1'b1);
		put_word(EV_UP, -40, 40, 32'd2050, 1'b1);
		put_word(EV_DOWN, 0, 0, 32'd5000, 1'b1);
		put_word(EV_MOVE, 0, 30, 32'd5001, 1'b1);
		put_word(EV_UP, 0, 100, 32'd4000, 1'b1);
		put_word(EV_DOWN, 0, 0, 32'd6000, 1'b1);
		put_word(EV_MOVE, 25, 0, 32'd6001, 1'b1);
		put_word(EV_UP, 100, 0, 32'd7000, 1'b1);
		put_word(EV_DOWN, 0, 0, 32'd9000, 1'b1);
		put_word(EV_CANCEL, 0, 0, 32'd9001, 1'b1);
		put_word(EV_UP, 0, 0, 32'd9002, 1'b1);
	endtask

	task automatic tap_sequence(int x, int y);
		bit f;
		int n;
		f = ($urandom_range(0, 9) != 0);
		put_word(EV_DOWN, x, y, cur_t, f);
		n = $urandom_range(0, 2);
		repeat (n) begin
			cur_t += $urandom_range(0, 30);
			put_word(EV_MOVE, x + jitter(s_slop), y + jitter(s_slop), cur_t, f);
		end
		cur_t += $urandom_range(0, 150);
		put_word(EV_UP, x + jitter(s_slop), y + jitter(s_slop), cur_t, f);
	endtask

	task automatic swipe_sequence(int x, int y);
		bit          f;
		int          n;
		int          off;
		int          reach;
		int          ux;
		int          uy;
		logic [31:0] t0;
		f = $urandom_range(0, 1);
		t0 = cur_t;
		put_word(EV_DOWN, x, y, t0, f);
		off = s_slop + 1 + $urandom_range(0, 20);
		if ($urandom_range(0, 9) == 0)
			off = $urandom_range(0, s_slop);
		if ($urandom_range(0, 1))
			off = -off;
		if ($urandom_range(0, 1))
			put_word(EV_MOVE, x + off, y + jitter(s_slop), t0 + 1, f);
		else
			put_word(EV_MOVE, x + jitter(s_slop), y + off, t0 + 1, f);
		n = $urandom_range(0, 2);
		repeat (n)
			put_word(EV_MOVE, x + jitter(2 * s_slop + 8), y + jitter(2 * s_slop + 8), t0 + 2, f);
		reach = 2 * s_min + 20;
		ux = jitter(reach);
		uy = ($urandom_range(0, 2) == 0) ? ux * (($urandom_range(0, 1)) ? 1 : -1)
		                                 : jitter(reach);
		if ($urandom_range(0, 19) == 0)
			cur_t = t0 - $urandom_range(1, 1000);
		else
			cur_t = t0 + $urandom_range(0, s_dur + 100);
		put_word(EV_UP, x + ux, y + uy, cur_t, f);
	endtask

	task automatic random_gesture();
		int r;
		int n;
		int x;
		int y;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 4) != 0) begin
			x = jitter(1000);
			y = jitter(1000);
		end else begin
			x = int'($signed(16'($urandom)));
			y = int'($signed(16'($urandom)));
		end
		if ($urandom_range(0, 49) == 0)
			cur_t = $urandom;
		else
			cur_t += $urandom_range(0, 600);
		if (r < 30) begin
			tap_sequence(x, y);
		end else if (r < 50) begin
			tap_sequence(x, y);
			cur_t += $urandom_range(0, s_tmo + 40);
			tap_sequence(x + jitter(s_dslop + 4), y + jitter(s_dslop + 4));
		end else if (r < 80) begin
			swipe_sequence(x, y);
		end else if (r < 90) begin
			n = $urandom_range(1, 3);
			repeat (n)
				put_word(ev_kind_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
				         $urandom_range(0, 1));
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					put_word(EV_DOWN, x, y, cur_t, 1'b1);
					put_word(EV_CANCEL, x, y, cur_t + 1, 1'b1);
				end
				1: begin
					put_word(EV_DOWN, x, y, cur_t, 1'b1);
					put_word(EV_DOWN, x + jitter(50), y + jitter(50), cur_t + 5, 1'b1);
					put_word(EV_UP, x, y, cur_t + 9, 1'b1);
				end
				2: put_word(EV_UP, x, y, cur_t, 1'b1);
				default: begin
					put_word(EV_MOVE, x, y, cur_t, 1'b0);
					put_word(EV_CANCEL, x, y, cur_t, 1'b0);
				end
			endcase
		end
	endtask

	task automatic random_items(int n);
		int target;
		target = sent + n;
		while (sent < target)
			random_gesture();
	endtask

	initial begin
		pointer.valid = 1'b0;
		pointer.kind = EV_DOWN;
		pointer.pos_x = '0;
		pointer.pos_y = '0;
		pointer.stamp = '0;
		pointer.has_focus = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed();
		random_items(ITEMS_PER_PHASE);
		for (int phase = 1; phase < PHASES; phase++) begin
			settle();
			apply_setting(phase);
			if (phase == 1) begin
				// zero offset on the deciding axis
				put_word(EV_DOWN, 7, 7, 32'd100, 1'b1);
				put_word(EV_MOVE, 8, 7, 32'd100, 1'b1);
				put_word(EV_UP, 7, 7, 32'd100, 1'b1);
			end
			random_items(ITEMS_PER_PHASE);
		end
		pointer.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== touch_gesture_classifier.f =====
rtl/core/gtc_pkg.sv
rtl/core/gtc_if.sv
rtl/core/gtc_cfg.sv
rtl/core/gtc_core.sv
rtl/core/touch_gesture_classifier.sv
tb/gesture_checker.sv
tb/tb_touch_gesture_classifier.sv
